// File: sv/sbs_pkg.sv
// Shared types and constants for the select/blend s-curve unit.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package sbs_pkg;

  // Sample and register widths
  localparam int SAMPLE_W  = 16;
  localparam int FALL_W    = 14;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF = 2'd2;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] LOWER_RST   = SAMPLE_W'(-4096);
  localparam logic signed [SAMPLE_W-1:0] UPPER_RST   = SAMPLE_W'(4096);
  localparam logic [FALL_W-1:0]          FALLOFF_RST = '0;

  // Edge arithmetic is wide enough that bound +/- falloff never wraps
  localparam int EDGE_W = ((SAMPLE_W > FALL_W) ? SAMPLE_W : FALL_W) + 2;

  // Blend distance and divisor (2 * falloff) widths
  localparam int NUM_W = FALL_W + 1;

  // Normalized distance a is unsigned Q16; weight is Q16 in [0, 1]
  localparam int A_W        = 16;
  localparam int W_W        = A_W + 1;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = A_W / DIV_STEP;

  // Region select codes
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_A      = 2'd0;
  localparam sel_t SEL_B      = 2'd1;
  localparam sel_t SEL_BLD_LO = 2'd2;
  localparam sel_t SEL_BLD_HI = 2'd3;

  // Request as it enters the pipe
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] control;
    logic signed [SAMPLE_W-1:0] src_a;
    logic signed [SAMPLE_W-1:0] src_b;
    logic                       last;
  } in_item_t;

  // Request after region decode: blend runs from x toward y; plain picks use x
  typedef struct packed {
    logic                       valid;
    sel_t                       sel;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       last;
  } item_t;

endpackage

// File: sv/sbs_region.sv
// Region decode stage: classifies the control sample against the band edges.
// Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_region import sbs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] band_lo,
  input  logic signed [SAMPLE_W-1:0] band_hi,
  input  logic [FALL_W-1:0]          edge_falloff,
  input  in_item_t                   in_item,
  output item_t                      out_item,
  output logic [NUM_W-1:0]           out_num
);

  logic signed [EDGE_W-1:0] lo_m;
  logic signed [EDGE_W-1:0] lo_p;
  logic signed [EDGE_W-1:0] hi_m;
  logic signed [EDGE_W-1:0] hi_p;
  logic signed [EDGE_W-1:0] lo_ext;
  logic signed [EDGE_W-1:0] hi_ext;
  logic signed [EDGE_W-1:0] f_ext;
  logic                     hard;

  logic signed [EDGE_W-1:0] c_ext;
  logic signed [EDGE_W-1:0] blend_dist;
  item_t                    item_next;
  logic [NUM_W-1:0]         num_next;

  // Precompute the band edges; registers must only change while idle, the block does not enforce it
  assign lo_ext = EDGE_W'(band_lo);
  assign hi_ext = EDGE_W'(band_hi);
  assign f_ext  = $signed(EDGE_W'(edge_falloff));

  always_ff @(posedge clk) begin
    lo_m <= lo_ext - f_ext;
    lo_p <= lo_ext + f_ext;
    hi_m <= hi_ext - f_ext;
    hi_p <= hi_ext + f_ext;
    hard <= (edge_falloff == '0);
  end

  // Pick the region, the blend endpoints and the distance into the blend
  always_comb begin
    c_ext          = EDGE_W'(in_item.control);
    blend_dist     = '0;
    item_next      = '0;
    item_next.valid = in_item.valid;
    item_next.last  = in_item.last;
    item_next.sel   = SEL_A;
    item_next.x     = in_item.src_a;
    item_next.y     = in_item.src_b;
    if (hard) begin
      if (c_ext < lo_ext || c_ext > hi_ext) begin
        item_next.sel = SEL_A;
        item_next.x   = in_item.src_a;
      end else begin
        item_next.sel = SEL_B;
        item_next.x   = in_item.src_b;
      end
    end else if (c_ext < lo_m) begin
      item_next.sel = SEL_A;
      item_next.x   = in_item.src_a;
    end else if (c_ext < lo_p) begin
      item_next.sel = SEL_BLD_LO;
      item_next.x   = in_item.src_a;
      item_next.y   = in_item.src_b;
      blend_dist    = c_ext - lo_m;
    end else if (c_ext < hi_m) begin
      item_next.sel = SEL_B;
      item_next.x   = in_item.src_b;
    end else if (c_ext < hi_p) begin
      item_next.sel = SEL_BLD_HI;
      item_next.x   = in_item.src_b;
      item_next.y   = in_item.src_a;
      blend_dist    = c_ext - hi_m;
    end else begin
      item_next.sel = SEL_A;
      item_next.x   = in_item.src_a;
    end
    // Distance lies in [0, 2 * falloff) inside a blend region
    num_next = blend_dist[NUM_W-1:0];
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= item_next.valid;
    end
    out_item.sel  <= item_next.sel;
    out_item.x    <= item_next.x;
    out_item.y    <= item_next.y;
    out_item.last <= item_next.last;
    out_num       <= num_next;
  end

endmodule

// File: sv/sbs_divider.sv
// Pipelined restoring divider: a = floor(num * 2^16 / (2 * falloff)).
// Two quotient bits per stage. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_divider import sbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [FALL_W-1:0] edge_falloff,
  input  item_t             in_item,
  input  logic [NUM_W-1:0]  in_num,
  output item_t             out_item,
  output logic [A_W-1:0]    out_quo
);

  item_t            pipe [DIV_STAGES];
  logic [NUM_W-1:0] rem  [DIV_STAGES];
  logic [A_W-1:0]   quo  [DIV_STAGES];
  logic [NUM_W-1:0] den;

  // Divisor is twice the falloff
  assign den = {edge_falloff, 1'b0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    item_t            src_item;
    logic [NUM_W-1:0] src_rem;
    logic [A_W-1:0]   src_quo;
    logic [NUM_W-1:0] rem_next;
    logic [A_W-1:0]   quo_next;

    if (k == 0) begin : g_first
      assign src_item = in_item;
      assign src_rem  = in_num;
      assign src_quo  = '0;
    end else begin : g_rest
      assign src_item = pipe[k-1];
      assign src_rem  = rem[k-1];
      assign src_quo  = quo[k-1];
    end

    // Shift, compare and subtract once per quotient bit
    always_comb begin
      logic [NUM_W:0] r2;
      logic           qbit;
      rem_next = src_rem;
      quo_next = src_quo;
      for (int j = 0; j < DIV_STEP; j++) begin
        r2   = {rem_next, 1'b0};
        qbit = 1'b0;
        if (r2 >= {1'b0, den}) begin
          r2   = r2 - {1'b0, den};
          qbit = 1'b1;
        end
        rem_next = r2[NUM_W-1:0];
        quo_next = {quo_next[A_W-2:0], qbit};
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k].valid <= 1'b0;
      end else begin
        pipe[k].valid <= src_item.valid;
      end
      pipe[k].sel  <= src_item.sel;
      pipe[k].x    <= src_item.x;
      pipe[k].y    <= src_item.y;
      pipe[k].last <= src_item.last;
      rem[k]       <= rem_next;
      quo[k]       <= quo_next;
    end
  end

  assign out_item = pipe[DIV_STAGES-1];
  assign out_quo  = quo[DIV_STAGES-1];

endmodule

// File: sv/sbs_blend.sv
// S-curve weight and blend stages with output register.
// w = a*a*(3-2a) in Q16, result = x + round((y-x)*w), saturated. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_blend import sbs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  item_t                      in_item,
  input  logic [A_W-1:0]             in_a,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] blended_value,
  output logic                       frame_end_out
);

  localparam int T_W  = A_W + 2;
  localparam int SQ_W = 2 * A_W;
  localparam int PR_W = SQ_W + T_W;
  localparam int D_W  = SAMPLE_W + 1;
  localparam int P_W  = D_W + W_W + 1;
  localparam int R_W  = P_W + 1;

  localparam logic [T_W-1:0]        THREE  = T_W'(3) << A_W;
  localparam logic [W_W-1:0]        W_ONE  = W_W'(1) << A_W;
  localparam logic signed [R_W-1:0] HALF   = R_W'(1) << (A_W - 1);
  localparam logic signed [R_W-1:0] R_MAX  = R_W'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [R_W-1:0] R_MIN  = R_W'(-(longint'(1) <<< (SAMPLE_W - 1)));

  item_t               sq_item;
  logic [SQ_W-1:0]     sq;
  logic [T_W-1:0]      tfac;
  item_t               w_item;
  logic [W_W-1:0]      weight;
  item_t               p_item;
  logic signed [P_W-1:0] prod_p;

  logic [PR_W-1:0]     prod_w;
  logic [T_W-1:0]      w_raw;
  logic [W_W-1:0]      w_next;
  logic signed [D_W-1:0] diff;
  logic signed [P_W-1:0] p_next;
  logic signed [R_W-1:0] rnd;
  logic signed [R_W-1:0] sum;
  logic signed [SAMPLE_W-1:0] out_next;

  // Square a and form 3 - 2a
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_item.valid <= 1'b0;
    end else begin
      sq_item.valid <= in_item.valid;
    end
    sq_item.sel  <= in_item.sel;
    sq_item.x    <= in_item.x;
    sq_item.y    <= in_item.y;
    sq_item.last <= in_item.last;
    sq           <= SQ_W'(in_a) * SQ_W'(in_a);
    tfac         <= THREE - T_W'({in_a, 1'b0});
  end

  // Weight = (a^2 * (3 - 2a)) >> 32, clamped to one
  always_comb begin
    prod_w = PR_W'(sq) * PR_W'(tfac);
    w_raw  = prod_w[PR_W-1:SQ_W];
    if (w_raw > T_W'(W_ONE)) begin
      w_next = W_ONE;
    end else begin
      w_next = w_raw[W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_item.valid <= 1'b0;
    end else begin
      w_item.valid <= sq_item.valid;
    end
    w_item.sel  <= sq_item.sel;
    w_item.x    <= sq_item.x;
    w_item.y    <= sq_item.y;
    w_item.last <= sq_item.last;
    weight      <= w_next;
  end

  // Scale the endpoint difference by the weight
  always_comb begin
    diff   = D_W'(w_item.y) - D_W'(w_item.x);
    p_next = P_W'(diff) * $signed(P_W'(weight));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_item.valid <= 1'b0;
    end else begin
      p_item.valid <= w_item.valid;
    end
    p_item.sel  <= w_item.sel;
    p_item.x    <= w_item.x;
    p_item.y    <= w_item.y;
    p_item.last <= w_item.last;
    prod_p      <= p_next;
  end

  // Round to nearest (ties up), add to x, saturate; plain picks pass x
  always_comb begin
    rnd = (R_W'(prod_p) + HALF) >>> A_W;
    sum = rnd + R_W'(p_item.x);
    case (p_item.sel)
      SEL_BLD_LO, SEL_BLD_HI: begin
        if (sum > R_MAX) begin
          out_next = R_MAX[SAMPLE_W-1:0];
        end else if (sum < R_MIN) begin
          out_next = R_MIN[SAMPLE_W-1:0];
        end else begin
          out_next = sum[SAMPLE_W-1:0];
        end
      end
      default: begin
        out_next = p_item.x;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_item.valid;
    end
    blended_value <= out_next;
    frame_end_out <= p_item.last;
  end

endmodule

// File: sv/select_blend_scurve_unit.sv
// Top level of the select/blend s-curve unit: config registers, input stage, pipe.
// Depends on sbs_pkg, sbs_region, sbs_divider, sbs_blend.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   request  | start / busy            | control_value, source_a, source_b, frame_end
//   result   | done (one-cycle strobe) | blended_value, frame_end_out
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request per cycle; busy stays low. Each request passes through the input
// register, region decode, eight divider stages (two quotient bits each), square,
// weight multiply, blend multiply, round and output register.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipe advances every cycle.
`timescale 1ns / 1ps

module select_blend_scurve_unit import sbs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] control_value,
  input  logic signed [SAMPLE_W-1:0] source_a,
  input  logic signed [SAMPLE_W-1:0] source_b,
  input  logic                       frame_end,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] blended_value,
  output logic                       frame_end_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data
);

  logic signed [SAMPLE_W-1:0] band_lo;
  logic signed [SAMPLE_W-1:0] band_hi;
  logic [FALL_W-1:0]          edge_falloff;

  in_item_t         in_reg;
  item_t            reg_item;
  logic [NUM_W-1:0] reg_num;
  item_t            div_item;
  logic [A_W-1:0]   div_quo;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Config register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      band_lo      <= LOWER_RST;
      band_hi      <= UPPER_RST;
      edge_falloff <= FALLOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOWER:   band_lo      <= $signed(cfg_data);
        REG_UPPER:   band_hi      <= $signed(cfg_data);
        REG_FALLOFF: edge_falloff <= cfg_data[FALL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg.valid <= 1'b0;
    end else begin
      in_reg.valid <= start && !busy;
    end
    in_reg.control <= control_value;
    in_reg.src_a   <= source_a;
    in_reg.src_b   <= source_b;
    in_reg.last    <= frame_end;
  end

  sbs_region u_region (
    .clk          (clk),
    .rst          (rst),
    .band_lo      (band_lo),
    .band_hi      (band_hi),
    .edge_falloff (edge_falloff),
    .in_item      (in_reg),
    .out_item     (reg_item),
    .out_num      (reg_num)
  );

  sbs_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .edge_falloff (edge_falloff),
    .in_item      (reg_item),
    .in_num       (reg_num),
    .out_item     (div_item),
    .out_quo      (div_quo)
  );

  sbs_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .in_item       (div_item),
    .in_a          (div_quo),
    .done          (done),
    .blended_value (blended_value),
    .frame_end_out (frame_end_out)
  );

endmodule

// File: dv/select_blend_scurve_unit_tb.sv
// Self-checking testbench for select_blend_scurve_unit: drives pixel requests
// and band register writes, predicts every blended result and compares them.
// Depends on sbs_pkg and the select_blend_scurve_unit RTL.
`timescale 1ns / 1ps

module select_blend_scurve_unit_tb;
  import sbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int     FALL_MAX   = 2 ** FALL_W - 1;
  localparam longint Q16_ONE    = 65536;
  localparam longint Q16_HALF   = 32768;

  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 32;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
    int                         seq;
  } pixel_result_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] control_value;
  logic signed [SAMPLE_W-1:0] source_a;
  logic signed [SAMPLE_W-1:0] source_b;
  logic                       frame_end;
  logic                       done;
  logic signed [SAMPLE_W-1:0] blended_value;
  logic                       frame_end_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [SAMPLE_W-1:0]        cfg_data;

  // Shadow copy of the band registers
  logic signed [SAMPLE_W-1:0] band_lo;
  logic signed [SAMPLE_W-1:0] band_hi;
  logic [FALL_W-1:0]          falloff;

  pixel_result_t pending_pixels[$];
  pixel_result_t want;

  int  errors;
  int  sent_count;
  int  results_seen;
  int  cfg_writes;
  int  band_settings;
  int  stall_cycles;
  bit  gaps_on;
  bit  req_held;
  bit  cfg_held;

  select_blend_scurve_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .control_value (control_value),
    .source_a      (source_a),
    .source_b      (source_b),
    .frame_end     (frame_end),
    .done          (done),
    .blended_value (blended_value),
    .frame_end_out (frame_end_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Smoothstep weight a*a*(3-2a) in Q16 on the normalized edge distance
  function automatic longint scurve_q16(input longint offset, input longint span);
    longint a;
    longint w;
    if (offset < 0) offset = 0;
    a = (offset * Q16_ONE) / span;
    if (a > Q16_ONE) a = Q16_ONE;
    w = (a * a * (3 * Q16_ONE - 2 * a)) >>> 32;
    if (w > Q16_ONE) w = Q16_ONE;
    if (w < 0) w = 0;
    return w;
  endfunction

  // Move from x toward y by weight w, round half up, saturate
  function automatic longint mix_q16(input longint x, input longint y, input longint w);
    longint v;
    v = x + (((y - x) * w + Q16_HALF) >>> 16);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v;
  endfunction

  // Predict the blended pixel for one request under the current band setting
  function automatic pixel_result_t predict_pixel(input logic signed [SAMPLE_W-1:0] ctl,
                                                  input logic signed [SAMPLE_W-1:0] src0,
                                                  input logic signed [SAMPLE_W-1:0] src1,
                                                  input logic last);
    pixel_result_t res;
    longint c, s0, s1, f, lo, hi, r;
    c  = ctl;
    s0 = src0;
    s1 = src1;
    f  = falloff;
    lo = band_lo;
    hi = band_hi;
    // Ordered region tests: the first match wins, even if blend regions overlap
    if (f > 0) begin
      if (c < lo - f) r = s0;
      else if (c < lo + f) r = mix_q16(s0, s1, scurve_q16(c - (lo - f), 2 * f));
      else if (c < hi - f) r = s1;
      else if (c < hi + f) r = mix_q16(s1, s0, scurve_q16(c - (hi - f), 2 * f));
      else r = s0;
    end else if (c < lo || c > hi) begin
      r = s0;
    end else begin
      r = s1;
    end
    res.value = r[SAMPLE_W-1:0];
    res.last  = last;
    res.seq   = sent_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one pixel request; keep start high when the next request follows at once
  task automatic send_pixel(input logic signed [SAMPLE_W-1:0] ctl,
                            input logic signed [SAMPLE_W-1:0] src0,
                            input logic signed [SAMPLE_W-1:0] src1,
                            input logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    if (gap > 0) begin
      if (req_held) begin
        start <= 1'b0;
        req_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    control_value <= ctl;
    source_a      <= src0;
    source_b      <= src1;
    frame_end     <= last;
    req_held = 1'b1;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(predict_pixel(ctl, src0, src1, last));
    sent_count++;
  endtask

  // Hold off requests until every outstanding result is back
  task automatic drain_results();
    if (req_held) begin
      start <= 1'b0;
      req_held = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write one band register; valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    if (req_held) begin
      start <= 1'b0;
      req_held = 1'b0;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_held = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOWER:   band_lo = data;
      REG_UPPER:   band_hi = data;
      REG_FALLOFF: falloff = data[FALL_W-1:0];
      default:     ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_band(input int lo, input int hi, input int fall_data);
    write_reg(REG_LOWER, SAMPLE_W'(lo));
    write_reg(REG_UPPER, SAMPLE_W'(hi));
    write_reg(REG_FALLOFF, SAMPLE_W'(fall_data));
    band_settings++;
  endtask

  // Hard switch at the reset band, edges and sample extremes
  task automatic test_default_band();
    send_pixel(-4097, 1000, -1000, 1'b0);
    send_pixel(-4096, 1000, -1000, 1'b1);
    send_pixel(4096, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(4097, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_pixel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
  endtask

  // Upper below lower with no falloff: source_a everywhere
  task automatic test_inverted_band();
    drain_results();
    set_band(256, -256, 0);
    send_pixel(0, -77, 77, 1'b0);
    send_pixel(256, -77, 77, 1'b1);
  endtask

  // Write to the index with no register behind it; band must not change
  task automatic test_unused_index();
    drain_results();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_pixel(-256, 123, -123, 1'b0);
  endtask

  // Walk both blend regions across their edges with full-scale sources
  task automatic test_soft_edges();
    drain_results();
    set_band(-8192, 8192, 2048);
    send_pixel(-10241, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(-10240, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(-8192, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_pixel(-6145, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(-6144, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pixel(6144, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pixel(8192, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_pixel(10239, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pixel(10240, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
  endtask

  // Edges past the sample range, overlapping blend regions, minimum falloff
  task automatic test_wide_edges();
    drain_results();
    set_band(SAMPLE_MIN, SAMPLE_MAX, FALL_MAX);
    send_pixel(SAMPLE_MIN, -20000, 20000, 1'b0);
    send_pixel(0, -20000, 20000, 1'b1);
    send_pixel(SAMPLE_MAX, -20000, 20000, 1'b0);
    drain_results();
    set_band(0, 16, 64);
    send_pixel(40, 3000, -3000, 1'b0);
    send_pixel(100, 3000, -3000, 1'b1);
    drain_results();
    // top data bits set: register keeps only the low falloff bits
    set_band(500, 600, 16'hC001);
    send_pixel(499, 4000, 8000, 1'b0);
    send_pixel(500, 4000, 8000, 1'b1);
  endtask

  // Random pixel, mostly clustered around the band and blend edges
  task automatic send_random_pixel();
    int lo, hi, fall, ctl, jitter;
    logic signed [SAMPLE_W-1:0] s0, s1;
    lo     = band_lo;
    hi     = band_hi;
    fall   = falloff;
    jitter = int'($urandom_range(0, 2 * fall + 8)) - fall - 4;
    case ($urandom_range(0, 7))
      0:       ctl = lo - fall + jitter;
      1:       ctl = lo + fall + jitter;
      2:       ctl = hi - fall + jitter;
      3:       ctl = hi + fall + jitter;
      4:       ctl = lo + jitter;
      5:       ctl = hi + jitter;
      default: ctl = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (ctl > SAMPLE_MAX) ctl = int'(SAMPLE_MAX);
    if (ctl < SAMPLE_MIN) ctl = int'(SAMPLE_MIN);
    s0 = SAMPLE_W'($urandom);
    s1 = SAMPLE_W'($urandom);
    if ($urandom_range(0, 7) == 0)
      s0 = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
    if ($urandom_range(0, 7) == 0)
      s1 = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
    send_pixel(SAMPLE_W'(ctl), s0, s1, 1'($urandom_range(0, 1)));
  endtask

  // Random traffic over a sequence of band settings, extremes first
  task automatic test_random_traffic();
    int lo, hi, fall, tmp;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: set_band(SAMPLE_MIN, SAMPLE_MAX, FALL_MAX);
        1: set_band(SAMPLE_MAX, SAMPLE_MIN, 0);
        2: set_band(SAMPLE_MIN, SAMPLE_MAX, 0);
        default: begin
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = int'($urandom_range(0, 65535)) - 32768;
          if ($urandom_range(0, 9) < 7 && lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          case ($urandom_range(0, 3))
            0:       fall = 0;
            1:       fall = $urandom_range(1, 600);
            2:       fall = $urandom_range(1, 4096);
            default: fall = $urandom_range(0, 65535);
          endcase
          set_band(lo, hi, fall);
          if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, SAMPLE_W'($urandom));
        end
      endcase
      // every fourth phase runs back-to-back requests
      gaps_on = (phase % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        send_random_pixel();
      end
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", blended_value));
      end else begin
        want = pending_pixels.pop_front();
        results_seen++;
        if (blended_value !== want.value)
          report_mismatch($sformatf("request %0d blended_value got %0d want %0d",
                                    want.seq, blended_value, want.value));
        if (frame_end_out !== want.last)
          report_mismatch($sformatf("request %0d frame_end_out got %b want %b",
                                    want.seq, frame_end_out, want.last));
      end
    end
  end

  // Abort when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    errors        = 0;
    sent_count    = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    band_settings = 1;
    stall_cycles  = 0;
    gaps_on       = 1'b1;
    req_held      = 1'b0;
    cfg_held      = 1'b0;
    band_lo       = LOWER_RST;
    band_hi       = UPPER_RST;
    falloff       = FALLOFF_RST;

    rst           <= 1'b1;
    start         <= 1'b0;
    control_value <= '0;
    source_a      <= '0;
    source_b      <= '0;
    frame_end     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_LOWER;
    cfg_data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_default_band();
    test_inverted_band();
    test_unused_index();
    test_soft_edges();
    test_wide_edges();
    test_random_traffic();

    // Drop all valids, let the pipe settle, then report
    drain_results();
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixel requests and checked %0d results", sent_count, results_seen);
    $display("across %0d band settings (%0d register writes), %0d mismatches",
             band_settings, cfg_writes, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sbs_pkg.sv
sv/sbs_region.sv
sv/sbs_divider.sv
sv/sbs_blend.sv
sv/select_blend_scurve_unit.sv
dv/select_blend_scurve_unit_tb.sv
